/* rtl/core/rpd_pkg.sv */
// Package for the RGB PWM dimmer: word types, register indexes, reset values.
package rpd_pkg;

  typedef struct packed {
    logic       action;
    logic [4:0] buttons;
  } in_word_t;

  typedef struct packed {
    logic       red_out;
    logic       green_out;
    logic       blue_out;
    logic [1:0] chosen_channel;
    logic [7:0] chosen_level;
    logic       display_update;
  } out_word_t;

  typedef enum logic [1:0] {
    CFG_PERIOD_TOP   = 2'd0,
    CFG_STEP_SIZE    = 2'd1,
    CFG_LEVEL_MAX    = 2'd2,
    CFG_PRESCALE_LOG = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 8;

  localparam logic       ACT_TICK   = 1'b0;
  localparam logic       ACT_BUTTON = 1'b1;

  localparam int KEY_UP    = 0;
  localparam int KEY_DOWN  = 1;
  localparam int KEY_LEFT  = 2;
  localparam int KEY_RIGHT = 3;
  localparam int KEY_OK    = 4;

  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [7:0] PERIOD_TOP_RST   = 8'd250;
  localparam logic [7:0] STEP_SIZE_RST    = 8'd25;
  localparam logic [7:0] LEVEL_MAX_RST    = 8'd250;
  localparam logic [2:0] PRESCALE_LOG_RST = 3'd7;

endpackage

/* rtl/core/rpd_core.sv */
// Dimmer state: config registers, levels, selection, compare registers and PWM counter.
module rpd_core #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               step_en,
  input  rpd_pkg::in_word_t                  step_in,
  output rpd_pkg::out_word_t                 step_out
);
  import rpd_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;

  logic [7:0] period_top_r, step_size_r, level_max_r;
  logic [2:0] prescale_log_r;

  logic [7:0] lvl_red_r, lvl_green_r, lvl_blue_r;
  logic [7:0] lvl_red_nxt, lvl_green_nxt, lvl_blue_nxt;
  logic [7:0] cmp_red_r, cmp_green_r, cmp_blue_r;
  logic [7:0] cmp_red_nxt, cmp_green_nxt, cmp_blue_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [6:0] pre_r, pre_nxt;
  logic [COUNT_WIDTH-1:0] pwm_r, pwm_nxt;

  logic [6:0] pre_last;
  logic [7:0] cur_lvl, lvl_up, lvl_dn;
  logic [8:0] up_sum;
  logic [7:0] chosen_nxt;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_top_r   <= PERIOD_TOP_RST;
      step_size_r    <= STEP_SIZE_RST;
      level_max_r    <= LEVEL_MAX_RST;
      prescale_log_r <= PRESCALE_LOG_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PERIOD_TOP:   period_top_r   <= cfg_wdata;
        CFG_STEP_SIZE:    step_size_r    <= cfg_wdata;
        CFG_LEVEL_MAX:    level_max_r    <= cfg_wdata;
        CFG_PRESCALE_LOG: prescale_log_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pre_last = 7'((8'd1 << prescale_log_r) - 8'd1);

    // selection 3 is unreachable; it falls to blue like any value above green
    case (sel_r)
      SEL_RED:   cur_lvl = lvl_red_r;
      SEL_GREEN: cur_lvl = lvl_green_r;
      default:   cur_lvl = lvl_blue_r;
    endcase

    // up acts first, then down on the result
    up_sum = {1'b0, cur_lvl} + {1'b0, step_size_r};
    if (step_in.buttons[KEY_UP]) begin
      lvl_up = (up_sum > {1'b0, level_max_r}) ? 8'd0 : up_sum[7:0];
    end else begin
      lvl_up = cur_lvl;
    end
    if (step_in.buttons[KEY_DOWN]) begin
      lvl_dn = (lvl_up < step_size_r) ? level_max_r : lvl_up - step_size_r;
    end else begin
      lvl_dn = lvl_up;
    end

    lvl_red_nxt   = lvl_red_r;
    lvl_green_nxt = lvl_green_r;
    lvl_blue_nxt  = lvl_blue_r;
    cmp_red_nxt   = cmp_red_r;
    cmp_green_nxt = cmp_green_r;
    cmp_blue_nxt  = cmp_blue_r;
    sel_nxt       = sel_r;
    pre_nxt       = pre_r;
    pwm_nxt       = pwm_r;

    if (step_in.action == ACT_TICK) begin
      if (pre_r >= pre_last) begin
        pre_nxt = 7'd0;
        if (CMP_W'(pwm_r) >= CMP_W'(period_top_r)) begin
          pwm_nxt = '0;
        end else begin
          pwm_nxt = pwm_r + 1'b1;
        end
      end else begin
        pre_nxt = pre_r + 7'd1;
      end
    end else begin
      case (sel_r)
        SEL_RED:   lvl_red_nxt   = lvl_dn;
        SEL_GREEN: lvl_green_nxt = lvl_dn;
        default:   lvl_blue_nxt  = lvl_dn;
      endcase
      if (step_in.buttons[KEY_LEFT]) begin
        sel_nxt = (sel_nxt == SEL_RED) ? SEL_BLUE : sel_nxt - 2'd1;
      end
      if (step_in.buttons[KEY_RIGHT]) begin
        sel_nxt = (sel_nxt >= SEL_BLUE) ? SEL_RED : sel_nxt + 2'd1;
      end
      if (step_in.buttons[KEY_OK]) begin
        cmp_red_nxt   = lvl_red_nxt;
        cmp_green_nxt = lvl_green_nxt;
        cmp_blue_nxt  = lvl_blue_nxt;
        pre_nxt       = 7'd0;
        pwm_nxt       = '0;
      end
    end

    case (sel_nxt)
      SEL_RED:   chosen_nxt = lvl_red_nxt;
      SEL_GREEN: chosen_nxt = lvl_green_nxt;
      default:   chosen_nxt = lvl_blue_nxt;
    endcase

    step_out.red_out        = CMP_W'(pwm_nxt) < CMP_W'(cmp_red_nxt);
    step_out.green_out      = CMP_W'(pwm_nxt) < CMP_W'(cmp_green_nxt);
    step_out.blue_out       = CMP_W'(pwm_nxt) < CMP_W'(cmp_blue_nxt);
    step_out.chosen_channel = sel_nxt;
    step_out.chosen_level   = chosen_nxt;
    step_out.display_update = (step_in.action == ACT_BUTTON) && (step_in.buttons != 5'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_red_r   <= 8'd0;
      lvl_green_r <= 8'd0;
      lvl_blue_r  <= 8'd0;
      cmp_red_r   <= 8'd0;
      cmp_green_r <= 8'd0;
      cmp_blue_r  <= 8'd0;
      sel_r       <= SEL_BLUE;
      pre_r       <= 7'd0;
      pwm_r       <= '0;
    end else if (step_en) begin
      lvl_red_r   <= lvl_red_nxt;
      lvl_green_r <= lvl_green_nxt;
      lvl_blue_r  <= lvl_blue_nxt;
      cmp_red_r   <= cmp_red_nxt;
      cmp_green_r <= cmp_green_nxt;
      cmp_blue_r  <= cmp_blue_nxt;
      sel_r       <= sel_nxt;
      pre_r       <= pre_nxt;
      pwm_r       <= pwm_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r != 2'd3) else $error("selection reached an unused code");

  a_ok_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_in.action == ACT_BUTTON && step_in.buttons[KEY_OK])
      |=> (pwm_r == '0 && pre_r == 7'd0))
    else $error("ok did not restart the counters");

  a_tick_keeps_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && step_in.action == ACT_TICK)
      |=> ($stable(cmp_red_r) && $stable(cmp_green_r) && $stable(cmp_blue_r)
           && $stable(lvl_red_r) && $stable(sel_r)))
    else $error("tick changed button state");
`endif

endmodule

/* rtl/core/rpd_skid.sv */
// Two-entry result buffer: output register plus skid register.
module rpd_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rpd_pkg::out_word_t push_word,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output rpd_pkg::out_word_t out_data
);
  import rpd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  out_word_t skid_word_r, skid_word_nxt;
  logic      pop;

  assign pop        = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_word_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_word_nxt   = out_word_r;
    skid_word_nxt  = skid_word_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        // skid full means no push this cycle
        out_word_nxt   = skid_word_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_word_nxt  = push_word;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_word_nxt  = push_word;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid holds a word ahead of output");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("word pushed into stalled output was lost");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && $stable(skid_word_r)))
    else $error("skid word changed while stalled");
`endif

endmodule

/* rtl/core/rgb_pwm_dimmer_buttons.sv */
// Top level of the three-channel RGB PWM dimmer with button control.
//
//   channel | ports                              | word
//   --------+------------------------------------+-------------------------------
//   input   | in_valid, in_ready, in_data        | action, buttons
//   result  | out_valid, out_ready, out_data     | pwm outputs, selection, level
//   config  | cfg_we, cfg_index, cfg_wdata       | period, step, max, prescale
//
// One word is accepted per cycle while in_ready is high. State update and
// result are computed in the accept cycle from the core registers and registered
// into out_data, or the second entry while out_data stalls, so input continues;
// in_ready drops only when both entries are full. rst_n is synchronous: config
// returns to its defaults, levels and compares to zero, selection to blue.
module rgb_pwm_dimmer_buttons #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rpd_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rpd_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [rpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rpd_pkg::*;

  logic      push;
  out_word_t step_word;

  assign push = in_valid && in_ready;

  rpd_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .step_en  (push),
    .step_in  (in_data),
    .step_out (step_word)
  );

  rpd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (step_word),
    .push_ready(in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
